### hw/rtl/crlf_response_line_parser_top_defines.svh
// Assertion macros for the reply line parser.
// Used by the top level only; no other dependencies.
`ifndef CRLF_RESPONSE_LINE_PARSER_TOP_DEFINES_SVH
`define CRLF_RESPONSE_LINE_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define CRLF_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define CRLF_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define CRLF_ASSERT_IMP(lbl, a, b, msg)
`define CRLF_ASSERT_NXT(lbl, a, b, msg)
`endif

`endif

### hw/rtl/crlf_pkg.sv
// Shared types and constants of the reply line parser.
// No dependencies; imported by every module of the block but the RAM.
package crlf_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int JOB_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_R  = 8'h52;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic [1:0] LINES_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DEVERR     = 3'd1,
    ST_STRAY_CR   = 3'd2,
    ST_STRAY_LF   = 3'd3,
    ST_MANY_LINES = 3'd4,
    ST_MANY_CHARS = 3'd5,
    ST_STRAY_CHAR = 3'd6
  } status_t;

  // One finished exchange: its status and how many stored bytes to read out.
  typedef struct packed {
    status_t              status;
    logic [JOB_CNT_W-1:0] cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Characters of "ERROR" by position; positions beyond the word never match.
  function automatic logic [7:0] error_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = CH_E;
      3'd1:    c = CH_R;
      3'd2:    c = CH_R;
      3'd3:    c = CH_O;
      3'd4:    c = CH_R;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/crlf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module crlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/crlf_front.sv
// Front end of the reply line parser: takes bytes, tracks framing, matches lines,
// writes the first line into the store and posts one job per exchange. Uses crlf_pkg.
module crlf_front
  import crlf_pkg::*;
#(
  parameter int LINE_MAX = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tuser,
  input  q_stat_t                     q_stat,
  input  logic                        store_busy,
  output logic                        q_push,
  output job_t                        q_job,
  output logic                        store_we,
  output logic [$clog2(LINE_MAX)-1:0] store_waddr,
  output logic [7:0]                  store_wdata
);

  localparam int CI_W = $clog2(LINE_MAX + 1);
  localparam int AW   = $clog2(LINE_MAX);

  logic            cr_seen_r, cr_seen_nxt;
  logic            in_line_r, in_line_nxt;
  logic [1:0]      lines_done_r, lines_done_nxt;
  logic [CI_W-1:0] char_index_r, char_index_nxt;
  logic [CI_W-1:0] first_len_r, first_len_nxt;
  logic            ok_match_r, ok_match_nxt;
  logic            err_match_r, err_match_nxt;
  logic            finished_r, finished_nxt;

  logic            accept;
  logic [7:0]      c;
  logic            is_ok, is_err;
  logic            ok_hit, err_hit;
  logic            fault;
  status_t         fault_st;
  logic            line_end;
  logic [CI_W-1:0] readout_len;

  // Bytes of a new exchange wait while the previous line is still being read out.
  assign in_tready = !q_stat.full && !(store_busy && !finished_r);
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;

  assign is_ok  = ok_match_r && (char_index_r == CI_W'(2));
  assign is_err = err_match_r && (char_index_r == CI_W'(5));
  assign ok_hit = ((char_index_r == CI_W'(0)) && (c == CH_O)) ||
                  ((char_index_r == CI_W'(1)) && (c == CH_K));
  assign err_hit = (char_index_r < CI_W'(5)) && (c == error_char(char_index_r[2:0]));

  assign readout_len = (lines_done_r == 2'd1) ? first_len_r : '0;

  always_comb begin
    cr_seen_nxt    = cr_seen_r;
    in_line_nxt    = in_line_r;
    lines_done_nxt = lines_done_r;
    char_index_nxt = char_index_r;
    first_len_nxt  = first_len_r;
    ok_match_nxt   = ok_match_r;
    err_match_nxt  = err_match_r;
    finished_nxt   = finished_r;
    fault          = 1'b0;
    fault_st       = ST_STRAY_CHAR;
    line_end       = 1'b0;
    store_we       = 1'b0;

    if (accept) begin
      if (in_tuser == CMD_START) begin
        cr_seen_nxt    = 1'b0;
        in_line_nxt    = 1'b0;
        lines_done_nxt = '0;
        char_index_nxt = '0;
        first_len_nxt  = '0;
        ok_match_nxt   = 1'b1;
        err_match_nxt  = 1'b1;
        finished_nxt   = 1'b0;
      end else if (!finished_r) begin
        if (c == CH_CR) begin
          if (cr_seen_r) begin
            fault    = 1'b1;
            fault_st = ST_STRAY_CR;
          end else begin
            cr_seen_nxt = 1'b1;
          end
        end else if (c == CH_LF) begin
          if (!cr_seen_r) begin
            fault    = 1'b1;
            fault_st = ST_STRAY_LF;
          end else begin
            cr_seen_nxt = 1'b0;
            if (!in_line_r) begin
              in_line_nxt = 1'b1;
            end else begin
              in_line_nxt = 1'b0;
              if (lines_done_r >= LINES_LIMIT) begin
                fault    = 1'b1;
                fault_st = ST_MANY_LINES;
              end else begin
                line_end = 1'b1;
                if (lines_done_r == 2'd0) begin
                  first_len_nxt = char_index_r;
                end
                lines_done_nxt = lines_done_r + 2'd1;
                char_index_nxt = '0;
                ok_match_nxt   = 1'b1;
                err_match_nxt  = 1'b1;
                if (is_ok || is_err) begin
                  finished_nxt = 1'b1;
                end
              end
            end
          end
        end else if (cr_seen_r || !in_line_r) begin
          fault    = 1'b1;
          fault_st = ST_STRAY_CHAR;
        end else if ((lines_done_r >= LINES_LIMIT) ||
                     (char_index_r >= CI_W'(LINE_MAX))) begin
          fault    = 1'b1;
          fault_st = ST_MANY_CHARS;
        end else begin
          ok_match_nxt   = ok_match_r && ok_hit;
          err_match_nxt  = err_match_r && err_hit;
          store_we       = (lines_done_r == 2'd0);
          char_index_nxt = char_index_r + CI_W'(1);
        end
        if (fault) begin
          finished_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_push     = fault || (line_end && (is_ok || is_err));
    q_job.status = fault ? fault_st : (is_ok ? ST_OK : ST_DEVERR);
    if (fault) begin
      q_job.cnt = '0;
    end else if (32'(readout_len) > 32'(MAX_RESULTS)) begin
      q_job.cnt = JOB_CNT_W'(MAX_RESULTS);
    end else begin
      q_job.cnt = JOB_CNT_W'(readout_len);
    end
  end

  assign store_waddr = AW'(char_index_r);
  assign store_wdata = c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_seen_r    <= 1'b0;
      in_line_r    <= 1'b0;
      lines_done_r <= '0;
      char_index_r <= '0;
      first_len_r  <= '0;
      ok_match_r   <= 1'b1;
      err_match_r  <= 1'b1;
      finished_r   <= 1'b0;
    end else begin
      cr_seen_r    <= cr_seen_nxt;
      in_line_r    <= in_line_nxt;
      lines_done_r <= lines_done_nxt;
      char_index_r <= char_index_nxt;
      first_len_r  <= first_len_nxt;
      ok_match_r   <= ok_match_nxt;
      err_match_r  <= err_match_nxt;
      finished_r   <= finished_nxt;
    end
  end

endmodule

### hw/rtl/crlf_job_queue.sv
// Two-entry job queue between the parser front end and the read-out back end.
// Uses crlf_pkg for the job type.
module crlf_job_queue
  import crlf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/crlf_back.sv
// Back end of the reply line parser: takes jobs from the queue and drives the
// result stream, reading stored line bytes from the RAM. Uses crlf_pkg.
module crlf_back
  import crlf_pkg::*;
#(
  parameter int LINE_MAX = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  q_stat_t                     q_stat,
  input  job_t                        q_head,
  output logic                        q_pop,
  output logic                        store_re,
  output logic [$clog2(LINE_MAX)-1:0] store_raddr,
  input  logic [7:0]                  store_rdata,
  output logic                        busy,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  localparam int AW = $clog2(LINE_MAX);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_FETCH = 3'b010,
    BK_SHOW  = 3'b100
  } bk_state_t;

  bk_state_t            state_r, state_nxt;
  job_t                 job_r, job_nxt;
  logic [JOB_CNT_W-1:0] idx_r, idx_nxt;
  status_t              st_r, st_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 dv_r, dv_nxt;
  logic                 last_r, last_nxt;
  logic [JOB_CNT_W-1:0] rd_idx;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    byte_nxt  = byte_r;
    dv_nxt    = dv_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    store_re  = 1'b0;
    rd_idx    = idx_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
          if (q_head.cnt == '0) begin
            st_nxt    = q_head.status;
            byte_nxt  = 8'h00;
            dv_nxt    = 1'b0;
            last_nxt  = 1'b1;
            state_nxt = BK_SHOW;
          end else begin
            idx_nxt   = '0;
            rd_idx    = '0;
            store_re  = 1'b1;
            state_nxt = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        // Registered read data for idx_r is present in this cycle.
        st_nxt    = job_r.status;
        byte_nxt  = store_rdata;
        dv_nxt    = 1'b1;
        last_nxt  = (idx_r + JOB_CNT_W'(1) == job_r.cnt);
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_tready) begin
          if (last_r) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt   = idx_r + JOB_CNT_W'(1);
            rd_idx    = idx_r + JOB_CNT_W'(1);
            store_re  = 1'b1;
            state_nxt = BK_FETCH;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign store_raddr = AW'(rd_idx);
  assign busy        = (state_r != BK_IDLE);
  assign out_tvalid  = (state_r == BK_SHOW);
  assign out_tdata   = {5'b00000, byte_r, st_r};
  assign out_tuser   = dv_r;
  assign out_tlast   = last_r;

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    byte_r <= byte_nxt;
    dv_r   <= dv_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/crlf_response_line_parser_top.sv
// Top level of the reply line parser: front end, job queue, back end and line store.
// Depends on crlf_pkg, crlf_front, crlf_job_queue, crlf_back, crlf_ram and the defines header.
//
// The parser takes one item per clock cycle on the input stream while in_tready is
// high: a start item (tuser 0) clears it, a reply byte (tuser 1) advances the CR LF
// framing and line matching, and neither produces a result until the exchange ends.
// An exchange ends with exactly one status-only result (framing fault, or OK or
// ERROR as the only line or after an empty line) or with a read-out of the first
// line, one result per byte, status on each and tlast on the final one. Each byte
// of the read-out passes through the registered read of the line store and then
// the output register, and the next byte is fetched only once the current one is
// taken; a status-only result passes through the job queue and the output register
// after the closing byte. Bytes after the end are taken and ignored at full rate.
// Bytes of the next exchange are held off (in_tready low) until the previous
// read-out is complete, because they share the line store. The store has no reset
// and needs no clearing pass: only bytes written in the current exchange are ever read.
`include "crlf_response_line_parser_top_defines.svh"

module crlf_response_line_parser_top
  import crlf_pkg::*;
#(
  parameter int LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] status, [10:3] data_byte, [15:11] zero
  output logic        out_tuser,  // [0] data_valid
  output logic        out_tlast
);

  localparam int AW = $clog2(LINE_MAX);

  q_stat_t       q_stat;
  logic          q_push, q_pop;
  job_t          q_job, q_head;
  logic          store_we, store_re;
  logic [AW-1:0] store_waddr, store_raddr;
  logic [7:0]    store_wdata, store_rdata;
  logic          back_busy;
  logic          store_busy;

  assign store_busy = !q_stat.empty || back_busy;

  crlf_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_stat      (q_stat),
    .store_busy  (store_busy),
    .q_push      (q_push),
    .q_job       (q_job),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata)
  );

  crlf_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  crlf_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  crlf_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .store_re    (store_re),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata),
    .busy        (back_busy),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  `CRLF_ASSERT_IMP(a_store_write_free, store_we, !store_busy, "line store written during read-out")
  `CRLF_ASSERT_IMP(a_push_not_full, q_push, !q_stat.full, "job pushed into a full queue")
  `CRLF_ASSERT_IMP(a_status_only_last, out_tvalid && !out_tuser,
                   out_tlast && (out_tdata[10:3] == 8'h00), "status-only result not last")
  `CRLF_ASSERT_NXT(a_last_ends_run, out_tvalid && out_tready && out_tlast,
                   !out_tvalid, "result shown straight after the last one")

endmodule
